FILE: src/thermlin_pkg.sv
// Package with constants, types and coefficient tables for the thermistor linearizer.
package thermlin_pkg;

    // Input and output formats.
    localparam int ADC_BITS  = 12;
    localparam int FRAC_BITS = 8;
    localparam int RES_W     = 24;
    localparam int TEMP_W    = 16;
    localparam int STATUS_W  = 2;

    // Divider network: R = NUM_MULT*code / (DEN_BASE - DEN_MULT*code).
    localparam int NUM_MULT = 3300;
    localparam int DEN_BASE = 614250;
    localparam int DEN_MULT = 165;

    localparam int CODE_MAX   = (1 << ADC_BITS) - 1;
    localparam int NUM_W      = $clog2(NUM_MULT * CODE_MAX + 1) + FRAC_BITS;
    localparam int DEN_W      = $clog2(DEN_BASE + 1);
    localparam int PROD_W     = $clog2(DEN_MULT * CODE_MAX + 1);
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int QUO_W      = DIV_STAGES * DIV_STEPS;

    // Segment table.
    localparam int NSEG      = 11;
    localparam int SEG_W     = $clog2(NSEG);
    localparam int COEF_W    = 22;
    localparam int OFF_W     = 24;
    localparam int COEF_FRAC = 16;
    localparam int MUL_W     = COEF_W + RES_W + 1;
    localparam int ACC_W     = MUL_W + 1;
    localparam longint THR_SCALE  = 1000;
    localparam longint HOT_MILLI  = 1288;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(longint'(1) << (COEF_FRAC - 1));
    localparam logic signed [ACC_W-1:0] TEMP_MAX   = ACC_W'((longint'(1) << (TEMP_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] TEMP_MIN   = ACC_W'(-(longint'(1) << (TEMP_W - 1)));

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HOT     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    // Segment lower thresholds in milli-kilohms, top segment first.
    localparam longint SEG_THR_MILLI [NSEG] = '{
        89776, 53198, 32116, 19783, 12487, 8052, 5309, 3588, 2457, 1721, 1288
    };

    // Slopes and offsets, both with COEF_FRAC fractional bits.
    localparam logic signed [COEF_W-1:0] SEG_SLOPE [NSEG] = '{
        COEF_W'(-10267),  COEF_W'(-17917),  COEF_W'(-31086),  COEF_W'(-53139),
        COEF_W'(-89824),  COEF_W'(-147770), COEF_W'(-238921), COEF_W'(-380802),
        COEF_W'(-579452), COEF_W'(-890435), COEF_W'(-1329331)
    };

    localparam logic signed [OFF_W-1:0] SEG_OFF [NSEG] = '{
        OFF_W'(-388986), OFF_W'(297786),  OFF_W'(998371),  OFF_W'(1706598),
        OFF_W'(2432354), OFF_W'(3155923), OFF_W'(3889869), OFF_W'(4643119),
        OFF_W'(5355873), OFF_W'(6119959), OFF_W'(6875299)
    };

    // Divider pipeline payload.
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [DEN_W-1:0] den;
        logic             bad;
    } div_t;

    // Threshold in resistance units: R*1000 > T*2^F holds exactly when R > floor(T*2^F/1000).
    function automatic logic [RES_W-1:0] thr_q(input longint milli);
        return RES_W'((milli << FRAC_BITS) / THR_SCALE);
    endfunction

    // Restoring division, DIV_STEPS quotient bits per call.
    function automatic div_t div_stage(input div_t d);
        div_t           r;
        logic [DEN_W:0] t;
        r = d;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            t     = {r.rem, r.quo[QUO_W-1]};
            r.quo = {r.quo[QUO_W-2:0], 1'b0};
            if (t >= {1'b0, r.den})
            begin
                t        = t - {1'b0, r.den};
                r.quo[0] = 1'b1;
            end
            r.rem = t[DEN_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: src/thermistor_adc_to_temperature.sv
// Top level: pipelined ADC code to resistance and temperature conversion.
//
//   channel   signals                                        direction
//   input     in_valid, in_ready, adc_code                   into the block
//   output    out_valid, out_ready, resistance_q8,
//             temperature_q8, status                         out of the block
//
// One code enters per cycle unless stalled; stages: front, divider, select, multiply, output.
// The divider takes two quotient bits per stage, which sets the depth of the pipeline.
// Reset clears only the valid bits; data registers are loaded freely.
// All stages move together whenever the output register is empty or its transfer completes,
// so a stall freezes every item in place.
module thermistor_adc_to_temperature (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [11:0]                    adc_code,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [thermlin_pkg::RES_W-1:0] resistance_q8,
    output logic signed [thermlin_pkg::TEMP_W-1:0] temperature_q8,
    output logic [thermlin_pkg::STATUS_W-1:0] status
);
    import thermlin_pkg::*;

    logic advance;

    // Front stage: numerator and denominator.
    logic [ADC_BITS-1:0] code;
    logic [PROD_W-1:0]   den_prod;
    div_t                front_next;

    // Divider stages; entry 0 holds the front stage.
    div_t                  div_reg   [DIV_STAGES+1];
    logic [DIV_STAGES:0]   div_vld_reg;

    // Segment select stage.
    logic [RES_W-1:0]    res_next;
    logic [SEG_W-1:0]    seg_next;
    logic [STATUS_W-1:0] st_next;
    logic [RES_W-1:0]    sel_res_reg;
    logic [SEG_W-1:0]    sel_seg_reg;
    logic [STATUS_W-1:0] sel_st_reg;
    logic                sel_vld_reg;

    // Multiply stage.
    logic signed [MUL_W-1:0] prod_next;
    logic signed [MUL_W-1:0] mul_prod_reg;
    logic [RES_W-1:0]        mul_res_reg;
    logic [SEG_W-1:0]        mul_seg_reg;
    logic [STATUS_W-1:0]     mul_st_reg;
    logic                    mul_vld_reg;

    // Output stage.
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  temp_full;
    logic signed [TEMP_W-1:0] temp_next;
    logic [RES_W-1:0]         out_res_reg;
    logic signed [TEMP_W-1:0] out_temp_reg;
    logic [STATUS_W-1:0]      out_st_reg;
    logic                     out_vld_reg;

    assign advance  = !out_vld_reg || out_ready;
    assign in_ready = advance;

    // Front stage: den = DEN_BASE - DEN_MULT*code; zero or negative marks the code invalid.
    always_comb
    begin
        code            = adc_code[ADC_BITS-1:0];
        den_prod        = PROD_W'(DEN_MULT) * PROD_W'(code);
        front_next.bad  = den_prod >= PROD_W'(DEN_BASE);
        front_next.den  = DEN_W'(PROD_W'(DEN_BASE) - den_prod);
        front_next.quo  = (QUO_W'(NUM_MULT) * QUO_W'(code)) << FRAC_BITS;
        front_next.rem  = '0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            div_reg[0] <= front_next;
        end
    end

    for (genvar j = 1; j <= DIV_STAGES; j++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                div_reg[j] <= div_stage(div_reg[j-1]);
            end
        end
    end

    // Saturate resistance, pick the segment and set the status; the top-most exceeded threshold wins.
    always_comb
    begin
        logic [QUO_W-1:0] quo;
        quo = div_reg[DIV_STAGES].quo;
        if (|quo[QUO_W-1:RES_W])
        begin
            res_next = '1;
        end
        else
        begin
            res_next = quo[RES_W-1:0];
        end
        seg_next = SEG_W'(NSEG - 1);
        for (int i = NSEG - 1; i >= 0; i--)
        begin
            if (res_next > thr_q(SEG_THR_MILLI[i]))
            begin
                seg_next = SEG_W'(i);
            end
        end
        st_next = ST_OK;
        if (res_next <= thr_q(HOT_MILLI))
        begin
            st_next = ST_HOT;
        end
        if (div_reg[DIV_STAGES].bad)
        begin
            res_next = '0;
            st_next  = ST_INVALID;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sel_res_reg <= res_next;
            sel_seg_reg <= seg_next;
            sel_st_reg  <= st_next;
        end
    end

    assign prod_next = SEG_SLOPE[sel_seg_reg] * $signed({1'b0, sel_res_reg});

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mul_prod_reg <= prod_next;
            mul_res_reg  <= sel_res_reg;
            mul_seg_reg  <= sel_seg_reg;
            mul_st_reg   <= sel_st_reg;
        end
    end

    // Add offset, round to nearest with ties upward, then saturate; an invalid code gives zero.
    always_comb
    begin
        acc       = ACC_W'(mul_prod_reg) + (ACC_W'(SEG_OFF[mul_seg_reg]) <<< FRAC_BITS)
                    + ROUND_HALF;
        temp_full = acc >>> COEF_FRAC;
        if (temp_full > TEMP_MAX)
        begin
            temp_next = TEMP_MAX[TEMP_W-1:0];
        end
        else if (temp_full < TEMP_MIN)
        begin
            temp_next = TEMP_MIN[TEMP_W-1:0];
        end
        else
        begin
            temp_next = temp_full[TEMP_W-1:0];
        end
        if (mul_st_reg == ST_INVALID)
        begin
            temp_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg  <= mul_res_reg;
            out_temp_reg <= temp_next;
            out_st_reg   <= mul_st_reg;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_vld_reg <= '0;
            sel_vld_reg <= 1'b0;
            mul_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            div_vld_reg <= {div_vld_reg[DIV_STAGES-1:0], in_valid};
            sel_vld_reg <= div_vld_reg[DIV_STAGES];
            mul_vld_reg <= sel_vld_reg;
            out_vld_reg <= mul_vld_reg;
        end
    end

    assign out_valid      = out_vld_reg;
    assign resistance_q8  = out_res_reg;
    assign temperature_q8 = out_temp_reg;
    assign status         = out_st_reg;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the thermistor ADC code to temperature converter.
module tb;
    import thermlin_pkg::*;

    localparam int     CYCLE_LIMIT     = 200000;
    localparam int     DRAIN_CYCLES    = 30;
    localparam int     SEG_COUNT       = 11;
    localparam int     CODE_LAST_VALID = 3722;
    localparam longint RES_CEIL        = 64'd16777215;
    localparam longint HOT_LIMIT_MILLI = 1288;

    // Segment lower bounds in milli-kilohms, Q16 slopes and offsets, top segment first.
    localparam longint SEG_BOUND [SEG_COUNT] = '{
        89776, 53198, 32116, 19783, 12487, 8052, 5309, 3588, 2457, 1721, 1288
    };
    localparam longint SEG_GAIN [SEG_COUNT] = '{
        -10267, -17917, -31086, -53139, -89824, -147770,
        -238921, -380802, -579452, -890435, -1329331
    };
    localparam longint SEG_BIAS [SEG_COUNT] = '{
        -388986, 297786, 998371, 1706598, 2432354, 3155923,
        3889869, 4643119, 5355873, 6119959, 6875299
    };

    typedef struct {
        logic [RES_W-1:0]         res;
        logic signed [TEMP_W-1:0] temp;
        logic [STATUS_W-1:0]      st;
        int                       seg;
    } conv_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [11:0]              adc_code = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [RES_W-1:0]         resistance_q8;
    logic signed [TEMP_W-1:0] temperature_q8;
    logic [STATUS_W-1:0]      status;

    conv_t pending_conv[$];
    int    boundary_code [SEG_COUNT];
    int    seg_hits [SEG_COUNT];
    int    status_hits [4];
    bit    no_idle = 1'b0;
    int    error_count = 0;
    int    codes_sent = 0;
    int    results_checked = 0;
    int    cycle_count = 0;

    thermistor_adc_to_temperature u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .adc_code       (adc_code),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .resistance_q8  (resistance_q8),
        .temperature_q8 (temperature_q8),
        .status         (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d conversions outstanding",
                     cycle_count, pending_conv.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Resistance from the divider equation, then the segment line, rounded and clamped.
    function automatic conv_t convert_code(input logic [11:0] code);
        conv_t  c;
        longint den;
        longint res;
        longint acc;
        c.res  = '0;
        c.temp = '0;
        c.st   = ST_INVALID;
        c.seg  = -1;
        den = 614250 - 165 * longint'(code);
        if (den > 0)
        begin
            res = ((3300 * longint'(code)) * 256) / den;
            if (res > RES_CEIL)
                res = RES_CEIL;
            c.seg = SEG_COUNT - 1;
            for (int i = 0; i < SEG_COUNT; i++)
            begin
                if (res * 1000 > SEG_BOUND[i] * 256)
                begin
                    c.seg = i;
                    break;
                end
            end
            c.st = (res * 1000 <= HOT_LIMIT_MILLI * 256) ? ST_HOT : ST_OK;
            acc = SEG_GAIN[c.seg] * res + SEG_BIAS[c.seg] * 256;
            acc = (acc + 32768) >>> 16;
            if (acc > 32767)
                acc = 32767;
            if (acc < -32768)
                acc = -32768;
            c.res  = res[RES_W-1:0];
            c.temp = acc[TEMP_W-1:0];
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("Mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Valid is only lowered when a gap follows, so a back-to-back transfer never
    // sees a low and a high assignment in the same step.
    task automatic send_code(input logic [11:0] code);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        adc_code <= code;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_conv.push_back(convert_code(code));
        codes_sent++;
    endtask

    // Output side: random stall before each transfer, then check against the oldest entry.
    initial
    begin
        conv_t exp_c;
        int    stall;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (pending_conv.size() == 0)
                report_mismatch($sformatf("unexpected result res=%0d temp=%0d status=%0d",
                                          resistance_q8, temperature_q8, status));
            else
            begin
                exp_c = pending_conv.pop_front();
                results_checked++;
                if (resistance_q8 !== exp_c.res)
                    report_mismatch($sformatf("resistance %0d, expected %0d",
                                              resistance_q8, exp_c.res));
                if (temperature_q8 !== exp_c.temp)
                    report_mismatch($sformatf("temperature %0d, expected %0d (res %0d)",
                                              temperature_q8, exp_c.temp, exp_c.res));
                if (status !== exp_c.st)
                    report_mismatch($sformatf("status %0d, expected %0d (res %0d)",
                                              status, exp_c.st, exp_c.res));
                status_hits[exp_c.st]++;
                if (exp_c.seg >= 0)
                    seg_hits[exp_c.seg]++;
            end
        end
    end

    task automatic find_segment_boundaries();
        conv_t c;
        for (int i = 0; i < SEG_COUNT; i++)
        begin
            boundary_code[i] = CODE_LAST_VALID;
            for (int code = CODE_LAST_VALID; code >= 0; code--)
            begin
                c = convert_code(12'(code));
                if (c.res * 1000 > SEG_BOUND[i] * 256)
                    boundary_code[i] = code;
                else
                    break;
            end
        end
    endtask

    task automatic test_code_extremes();
        conv_t c;
        int    sat_code;
        send_code(12'd0);
        send_code(12'd1);
        send_code(12'd2);
        send_code(12'd4095);
        send_code(12'(CODE_LAST_VALID + 1));
        send_code(12'(CODE_LAST_VALID));
        send_code(12'h800);
        send_code(12'hAAA);
        send_code(12'h555);
        // The lowest code at which the resistance clamps, and the one just below it.
        sat_code = CODE_LAST_VALID;
        for (int code = CODE_LAST_VALID; code >= 0; code--)
        begin
            c = convert_code(12'(code));
            if (c.res != RES_CEIL)
                break;
            sat_code = code;
        end
        send_code(12'(sat_code));
        send_code(12'(sat_code - 1));
    endtask

    // First code inside each segment, plus the last code that is still hot.
    task automatic test_segment_boundaries();
        for (int i = 0; i < SEG_COUNT; i++)
            send_code(12'(boundary_code[i]));
        send_code(12'(boundary_code[SEG_COUNT-1] - 1));
    endtask

    task automatic test_random_codes(input int count);
        int pick;
        int code;
        for (int n = 0; n < count; n++)
        begin
            if (n % 64 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 5)
                code = $urandom_range(0, CODE_LAST_VALID);
            else if (pick < 7)
                code = $urandom_range(0, 4095);
            else
            begin
                code = boundary_code[$urandom_range(0, SEG_COUNT - 1)]
                       + $urandom_range(0, 6) - 3;
                if (code < 0)
                    code = 0;
            end
            send_code(12'(code));
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        int covered;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        find_segment_boundaries();
        test_code_extremes();
        test_segment_boundaries();
        test_random_codes(730);
        // Drop valid right at the last transfer so the final code is not sent twice.
        in_valid <= 1'b0;
        while (pending_conv.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        covered = 0;
        for (int i = 0; i < SEG_COUNT; i++)
            if (seg_hits[i] > 0)
                covered++;
        $display("Sent %0d ADC codes, checked %0d conversions: %0d normal, %0d hot, %0d invalid",
                 codes_sent, results_checked, status_hits[ST_OK], status_hits[ST_HOT],
                 status_hits[ST_INVALID]);
        $display("Segments reached: %0d of %0d, mismatches: %0d", covered, SEG_COUNT,
                 error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
